FILE: hw/rtl/srhd_pkg.sv
`timescale 1ns / 1ps

package srhd_pkg;

    // geometry formats
    localparam int COORD_WIDTH = 24;
    localparam int FRAC_BITS   = 8;
    localparam int DIR_WIDTH   = 16;
    localparam int DIR_FRAC    = 14;
    localparam int LEN_WIDTH   = COORD_WIDTH - 1;
    localparam int RECT_WIDTH  = 16;

    // signed position width: segment end points and rectangle edges both fit
    localparam int RECT_POS_W = RECT_WIDTH + 2 + FRAC_BITS;
    localparam int POS_W      = (COORD_WIDTH + 2 > RECT_POS_W) ? COORD_WIDTH + 2 : RECT_POS_W;
    // magnitude of any offset along the segment
    localparam int MAG_W      = COORD_WIDTH + 1;
    localparam int PROD_W     = 2 * MAG_W;
    localparam int QUO_W      = MAG_W;
    localparam int DEN_W      = MAG_W + 1;
    localparam int ROOT_W     = MAG_W;
    localparam int REM_W      = ROOT_W + 3;

    localparam int ONE_PIX    = 1 << FRAC_BITS;
    localparam int NEAR_VERT_SCALE = 100;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = COORD_WIDTH;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_X      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RAY_LENGTH = 3'd4;

    localparam logic [DIR_WIDTH-1:0] DIR_X_RESET = DIR_WIDTH'(1 << DIR_FRAC);

    // job queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    typedef logic signed [POS_W-1:0] t_pos;
    typedef logic [MAG_W-1:0]        t_mag;

    typedef enum logic [1:0] {
        KIND_REJECT,
        KIND_STEEP,
        KIND_SLOPED
    } t_kind;

    // ray set-up shared by front and back; user must keep it steady while items are in flight (not enforced)
    typedef struct packed {
        t_pos p1x;
        t_pos p1y;
        t_pos p2y;
        t_pos bx_lo;
        t_pos bx_hi;
        t_pos by_lo;
        t_pos by_hi;
        t_mag adx;
        t_mag ady;
        logic sdx;
        logic sdy;
        logic steep;
    } t_ray;

    // one classified rectangle
    typedef struct packed {
        t_kind kind;
        t_pos  min_x;
        t_pos  max_x;
        t_pos  rect_t;
        t_pos  rect_b;
    } t_job;

    function automatic t_mag mag_of(input t_pos v);
        t_pos n;
        n = v[POS_W-1] ? -v : v;
        return n[MAG_W-1:0];
    endfunction

    function automatic t_pos pos_min(input t_pos a, input t_pos b);
        return (a < b) ? a : b;
    endfunction

    function automatic t_pos pos_max(input t_pos a, input t_pos b);
        return (a > b) ? a : b;
    endfunction

endpackage

FILE: hw/rtl/segment_rect_hit_distance.sv
`timescale 1ns / 1ps

// channel        direction  handshake                 payload
// configuration  in         i_cfg_we                  i_cfg_idx, i_cfg_data
// rectangle      in         start high, busy low      i_rect_left/top/width/height
// result         out        o_strobe (one cycle)      o_hit, o_hit_distance
//
// one rectangle per cycle; each result passes through the two 25-stage
// quotient pipelines and the 25-stage root pipeline in the back end
// reset is synchronous and active low; it empties the pipeline and queue and
// restores the default ray, no clearing pass
// results cannot be held off, so the job queue drains every cycle and busy
// stays low in service
module segment_rect_hit_distance (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [srhd_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [srhd_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                                   start,
    output logic                                   busy,
    input  logic signed [srhd_pkg::RECT_WIDTH-1:0] i_rect_left,
    input  logic signed [srhd_pkg::RECT_WIDTH-1:0] i_rect_top,
    input  logic [srhd_pkg::RECT_WIDTH-1:0]        i_rect_width,
    input  logic [srhd_pkg::RECT_WIDTH-1:0]        i_rect_height,
    output logic                                   o_strobe,
    output logic                                   o_hit,
    output logic [srhd_pkg::COORD_WIDTH-1:0]       o_hit_distance
);
    import srhd_pkg::*;

    // a transaction is taken when start meets a free queue
    logic accept;
    logic q_full;
    logic push;
    logic q_valid;
    t_job f_job;
    t_job q_job;
    t_ray ray;

    assign busy   = q_full;
    assign accept = start && !busy;

    // front end: ray set-up, box rejection, x clip, classification
    srhd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_accept      (accept),
        .i_rect_left   (i_rect_left),
        .i_rect_top    (i_rect_top),
        .i_rect_width  (i_rect_width),
        .i_rect_height (i_rect_height),
        .o_ray         (ray),
        .o_push        (push),
        .o_job         (f_job)
    );

    // short job queue decoupling the two halves
    srhd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (f_job),
        .i_pop   (q_valid),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_job   (q_job)
    );

    // back end: y from the line slope, y clip, entry point, distance
    srhd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ray          (ray),
        .i_valid        (q_valid),
        .i_job          (q_job),
        .o_strobe       (o_strobe),
        .o_hit          (o_hit),
        .o_hit_distance (o_hit_distance)
    );

endmodule

FILE: hw/rtl/srhd_div.sv
`timescale 1ns / 1ps

module srhd_div (
    input  logic                           i_clk,
    input  logic [srhd_pkg::PROD_W-1:0]    i_num,
    input  logic [srhd_pkg::DEN_W-1:0]     i_den,
    output logic [srhd_pkg::QUO_W-1:0]     o_quo
);
    import srhd_pkg::*;

    // restoring division, one quotient bit per stage
    logic [PROD_W-1:0] r_rem [QUO_W];
    logic [DEN_W-1:0]  r_den [QUO_W];
    logic [QUO_W-1:0]  r_quo [QUO_W];

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        localparam int B = QUO_W - 1 - k;
        logic [PROD_W-1:0] rem_in;
        logic [DEN_W-1:0]  den_in;
        logic [QUO_W-1:0]  quo_in;
        logic [PROD_W:0]   sh;
        logic              ge;

        if (k == 0) begin : g_first
            assign rem_in = i_num;
            assign den_in = i_den;
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign den_in = r_den[k-1];
            assign quo_in = r_quo[k-1];
        end

        assign sh = (PROD_W + 1)'(den_in) << B;
        assign ge = {1'b0, rem_in} >= sh;

        always_ff @(posedge i_clk) begin
            r_rem[k] <= ge ? rem_in - sh[PROD_W-1:0] : rem_in;
            r_den[k] <= den_in;
            r_quo[k] <= quo_in | (QUO_W'(ge) << B);
        end
    end

    assign o_quo = r_quo[QUO_W-1];

endmodule

FILE: hw/rtl/srhd_sqrt.sv
`timescale 1ns / 1ps

module srhd_sqrt (
    input  logic                          i_clk,
    input  logic [srhd_pkg::PROD_W-1:0]   i_rad,
    output logic [srhd_pkg::ROOT_W-1:0]   o_root,
    output logic [srhd_pkg::REM_W-1:0]    o_rem
);
    import srhd_pkg::*;

    // digit-by-digit root, two radicand bits per stage
    logic [PROD_W-1:0] r_rad  [ROOT_W];
    logic [REM_W-1:0]  r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        localparam int J = ROOT_W - 1 - k;
        logic [PROD_W-1:0] rad_in;
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [REM_W-1:0]  rem_sh;
        logic [REM_W-1:0]  trial;
        logic              ge;

        if (k == 0) begin : g_first
            assign rad_in  = i_rad;
            assign rem_in  = '0;
            assign root_in = '0;
        end else begin : g_next
            assign rad_in  = r_rad[k-1];
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
        end

        assign rem_sh = {rem_in[REM_W-3:0], rad_in[2*J+1:2*J]};
        assign trial  = {1'b0, root_in, 2'b01};
        assign ge     = rem_sh >= trial;

        always_ff @(posedge i_clk) begin
            r_rad[k]  <= rad_in;
            r_rem[k]  <= ge ? rem_sh - trial : rem_sh;
            r_root[k] <= {root_in[ROOT_W-2:0], ge};
        end
    end

    assign o_root = r_root[ROOT_W-1];
    assign o_rem  = r_rem[ROOT_W-1];

endmodule

FILE: hw/rtl/srhd_queue.sv
`timescale 1ns / 1ps

module srhd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  srhd_pkg::t_job i_job,
    input  logic           i_pop,
    output logic           o_valid,
    output logic           o_full,
    output srhd_pkg::t_job o_job
);
    import srhd_pkg::*;

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;
    logic              do_pop;

    assign o_valid = r_count != '0;
    assign o_full  = r_count == (QPTR_W + 1)'(QUEUE_DEPTH);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: hw/rtl/srhd_front.sv
`timescale 1ns / 1ps

module srhd_front (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [srhd_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [srhd_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                                   i_accept,
    input  logic signed [srhd_pkg::RECT_WIDTH-1:0] i_rect_left,
    input  logic signed [srhd_pkg::RECT_WIDTH-1:0] i_rect_top,
    input  logic [srhd_pkg::RECT_WIDTH-1:0]        i_rect_width,
    input  logic [srhd_pkg::RECT_WIDTH-1:0]        i_rect_height,
    output srhd_pkg::t_ray                         o_ray,
    output logic                                   o_push,
    output srhd_pkg::t_job                         o_job
);
    import srhd_pkg::*;

    localparam int OFS_W = DIR_WIDTH + LEN_WIDTH + 1;
    localparam int N100_W = MAG_W + 7;

    // rounded dir * len / 2^14, ties away from zero
    function automatic t_pos end_offset(input logic [DIR_WIDTH-1:0] dir,
                                        input logic [LEN_WIDTH-1:0] len);
        logic signed [OFS_W-1:0] prod;
        logic [OFS_W-1:0]        pmag;
        logic [OFS_W-1:0]        rsum;
        t_pos                    m;
        prod = $signed(dir) * $signed({1'b0, len});
        pmag = prod[OFS_W-1] ? -prod : prod;
        rsum = pmag + OFS_W'(1 << (DIR_FRAC - 1));
        m    = t_pos'(rsum[OFS_W-1:DIR_FRAC]);
        return prod[OFS_W-1] ? -m : m;
    endfunction

    logic [COORD_WIDTH-1:0] r_org_x;
    logic [COORD_WIDTH-1:0] r_org_y;
    logic [DIR_WIDTH-1:0]   r_dir_x;
    logic [DIR_WIDTH-1:0]   r_dir_y;
    logic [LEN_WIDTH-1:0]   r_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org_x <= '0;
            r_org_y <= '0;
            r_dir_x <= DIR_X_RESET;
            r_dir_y <= '0;
            r_len   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ORIGIN_X:   r_org_x <= i_cfg_data[COORD_WIDTH-1:0];
                CFG_ORIGIN_Y:   r_org_y <= i_cfg_data[COORD_WIDTH-1:0];
                CFG_DIR_X:      r_dir_x <= i_cfg_data[DIR_WIDTH-1:0];
                CFG_DIR_Y:      r_dir_y <= i_cfg_data[DIR_WIDTH-1:0];
                CFG_RAY_LENGTH: r_len   <= i_cfg_data[LEN_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // ray set-up: end point, then box, deltas and steepness
    t_pos r_p2x;
    t_pos r_p2y;
    t_pos p1x;
    t_pos p1y;
    t_pos dx;
    t_pos dy;
    t_mag n_adx;
    logic [N100_W-1:0] adx100;
    t_ray r_ray;

    assign p1x = t_pos'($signed(r_org_x));
    assign p1y = t_pos'($signed(r_org_y));
    assign dx  = r_p2x - p1x;
    assign dy  = r_p2y - p1y;
    assign n_adx  = mag_of(dx);
    assign adx100 = N100_W'(n_adx) * N100_W'(NEAR_VERT_SCALE);

    always_ff @(posedge i_clk) begin
        r_p2x <= p1x + end_offset(r_dir_x, r_len);
        r_p2y <= p1y + end_offset(r_dir_y, r_len);

        r_ray.p1x   <= p1x;
        r_ray.p1y   <= p1y;
        r_ray.p2y   <= r_p2y;
        r_ray.bx_lo <= pos_min(p1x, r_p2x);
        r_ray.bx_hi <= pos_max(p1x, r_p2x);
        r_ray.by_lo <= pos_min(p1y, r_p2y);
        r_ray.by_hi <= pos_max(p1y, r_p2y);
        r_ray.adx   <= n_adx;
        r_ray.ady   <= mag_of(dy);
        r_ray.sdx   <= dx[POS_W-1];
        r_ray.sdy   <= dy[POS_W-1];
        r_ray.steep <= adx100 <= N100_W'(ONE_PIX);
    end

    assign o_ray = r_ray;

    // item pipeline: capture, edges in Q.8, classify
    logic                         r_f1_v;
    logic signed [RECT_WIDTH-1:0] r_f1_left;
    logic signed [RECT_WIDTH-1:0] r_f1_top;
    logic [RECT_WIDTH-1:0]        r_f1_width;
    logic [RECT_WIDTH-1:0]        r_f1_height;

    logic r_f2_v;
    t_pos r_f2_l;
    t_pos r_f2_t;
    t_pos r_f2_r;
    t_pos r_f2_b;
    t_pos n_l;
    t_pos n_t;

    logic r_f3_v;
    t_job r_f3_job;

    t_pos one;
    t_pos lo_x;
    t_pos hi_x;
    t_pos max_x;
    t_pos lo_y;
    t_pos hi_y;
    logic box_ok;
    t_job n_job;

    assign n_l = t_pos'($signed(r_f1_left)) <<< FRAC_BITS;
    assign n_t = t_pos'($signed(r_f1_top)) <<< FRAC_BITS;

    assign one    = t_pos'(ONE_PIX);
    assign lo_x   = pos_max(r_ray.bx_lo, r_f2_l);
    assign hi_x   = pos_min(r_ray.bx_hi + one, r_f2_r);
    assign max_x  = pos_min(r_ray.bx_hi, r_f2_r);
    assign lo_y   = pos_max(r_ray.by_lo, r_f2_t);
    assign hi_y   = pos_min(r_ray.by_hi + one, r_f2_b);
    assign box_ok = (lo_x < hi_x) && (lo_y < hi_y) && (lo_x <= max_x);

    always_comb begin
        n_job.min_x  = lo_x;
        n_job.max_x  = max_x;
        n_job.rect_t = r_f2_t;
        n_job.rect_b = r_f2_b;
        if (!box_ok) begin
            n_job.kind = KIND_REJECT;
        end else if (r_ray.steep) begin
            n_job.kind = KIND_STEEP;
        end else begin
            n_job.kind = KIND_SLOPED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_v <= 1'b0;
            r_f2_v <= 1'b0;
            r_f3_v <= 1'b0;
        end else begin
            r_f1_v <= i_accept;
            r_f2_v <= r_f1_v;
            r_f3_v <= r_f2_v;
        end
        r_f1_left   <= i_rect_left;
        r_f1_top    <= i_rect_top;
        r_f1_width  <= i_rect_width;
        r_f1_height <= i_rect_height;
        r_f2_l      <= n_l;
        r_f2_t      <= n_t;
        r_f2_r      <= n_l + (t_pos'(r_f1_width) <<< FRAC_BITS);
        r_f2_b      <= n_t + (t_pos'(r_f1_height) <<< FRAC_BITS);
        r_f3_job    <= n_job;
    end

    assign o_push = r_f3_v;
    assign o_job  = r_f3_job;

endmodule

FILE: hw/rtl/srhd_back.sv
`timescale 1ns / 1ps

module srhd_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  srhd_pkg::t_ray                    i_ray,
    input  logic                              i_valid,
    input  srhd_pkg::t_job                    i_job,
    output logic                              o_strobe,
    output logic                              o_hit,
    output logic [srhd_pkg::COORD_WIDTH-1:0]  o_hit_distance
);
    import srhd_pkg::*;

    typedef struct packed {
        t_job job;
        logic neg0;
        logic neg1;
    } t_bdiv;

    // offsets of the clipped x bounds from the origin
    t_pos a0;
    t_pos a1;
    assign a0 = i_job.min_x - i_ray.p1x;
    assign a1 = i_job.max_x - i_ray.p1x;

    logic  r_b1_v;
    t_bdiv r_b1;
    t_mag  r_b1_a0;
    t_mag  r_b1_a1;

    logic              r_b2_v;
    t_bdiv             r_b2;
    logic [PROD_W-1:0] r_b2_p0;
    logic [PROD_W-1:0] r_b2_p1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_v <= 1'b0;
            r_b2_v <= 1'b0;
        end else begin
            r_b1_v <= i_valid;
            r_b2_v <= r_b1_v;
        end
        r_b1.job  <= i_job;
        r_b1.neg0 <= a0[POS_W-1] ^ i_ray.sdy ^ i_ray.sdx;
        r_b1.neg1 <= a1[POS_W-1] ^ i_ray.sdy ^ i_ray.sdx;
        r_b1_a0   <= mag_of(a0);
        r_b1_a1   <= mag_of(a1);
        r_b2      <= r_b1;
        r_b2_p0   <= PROD_W'(r_b1_a0) * PROD_W'(i_ray.ady);
        r_b2_p1   <= PROD_W'(r_b1_a1) * PROD_W'(i_ray.ady);
    end

    // rounded quotient: (2p + |dx|) / (2|dx|)
    logic [PROD_W-1:0] num0;
    logic [PROD_W-1:0] num1;
    logic [DEN_W-1:0]  den;
    logic [QUO_W-1:0]  q0;
    logic [QUO_W-1:0]  q1;

    assign num0 = {r_b2_p0[PROD_W-2:0], 1'b0} + PROD_W'(i_ray.adx);
    assign num1 = {r_b2_p1[PROD_W-2:0], 1'b0} + PROD_W'(i_ray.adx);
    assign den  = {i_ray.adx, 1'b0};

    srhd_div u_div0 (
        .i_clk (i_clk),
        .i_num (num0),
        .i_den (den),
        .o_quo (q0)
    );

    srhd_div u_div1 (
        .i_clk (i_clk),
        .i_num (num1),
        .i_den (den),
        .o_quo (q1)
    );

    // side data alongside the dividers
    logic  r_dl_v [QUO_W];
    t_bdiv r_dl   [QUO_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < QUO_W; k++) begin
                r_dl_v[k] <= 1'b0;
            end
        end else begin
            r_dl_v[0] <= r_b2_v;
            for (int k = 1; k < QUO_W; k++) begin
                r_dl_v[k] <= r_dl_v[k-1];
            end
        end
        r_dl[0] <= r_b2;
        for (int k = 1; k < QUO_W; k++) begin
            r_dl[k] <= r_dl[k-1];
        end
    end

    t_bdiv dl_out;
    t_pos  sq0;
    t_pos  sq1;
    t_pos  n_y0;
    t_pos  n_y1;
    assign dl_out = r_dl[QUO_W-1];
    assign sq0 = t_pos'(q0);
    assign sq1 = t_pos'(q1);

    always_comb begin
        if (dl_out.job.kind == KIND_SLOPED) begin
            n_y0 = dl_out.neg0 ? i_ray.p1y - sq0 : i_ray.p1y + sq0;
            n_y1 = dl_out.neg1 ? i_ray.p1y - sq1 : i_ray.p1y + sq1;
        end else begin
            n_y0 = i_ray.p1y;
            n_y1 = i_ray.p2y;
        end
    end

    // y range, clip, entry point, squared offsets and their sum
    logic r_b3_v;
    t_job r_b3_job;
    t_pos r_b3_y0;
    t_pos r_b3_y1;

    logic r_b4_v;
    logic r_b4_ok;
    t_pos r_b4_min_x;
    t_pos r_b4_max_x;
    t_pos r_b4_lo;
    t_pos r_b4_hi;

    logic r_b5_v;
    logic r_b5_ok;
    t_mag r_b5_ddx;
    t_mag r_b5_ddy;

    logic              r_b6_v;
    logic              r_b6_ok;
    logic [PROD_W-1:0] r_b6_sx;
    logic [PROD_W-1:0] r_b6_sy;

    logic              r_b7_v;
    logic              r_b7_ok;
    logic [PROD_W-1:0] r_b7_sum;

    t_pos n_lo;
    t_pos n_hi;
    t_pos ix;
    t_pos iy;

    assign n_lo = pos_max(pos_min(r_b3_y0, r_b3_y1), r_b3_job.rect_t);
    assign n_hi = pos_min(pos_max(r_b3_y0, r_b3_y1), r_b3_job.rect_b);
    assign ix   = (i_ray.p1x <= r_b4_min_x) ? r_b4_min_x : r_b4_max_x;
    assign iy   = (i_ray.p1y <= r_b4_lo) ? r_b4_lo : r_b4_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b3_v <= 1'b0;
            r_b4_v <= 1'b0;
            r_b5_v <= 1'b0;
            r_b6_v <= 1'b0;
            r_b7_v <= 1'b0;
        end else begin
            r_b3_v <= r_dl_v[QUO_W-1];
            r_b4_v <= r_b3_v;
            r_b5_v <= r_b4_v;
            r_b6_v <= r_b5_v;
            r_b7_v <= r_b6_v;
        end
        r_b3_job   <= dl_out.job;
        r_b3_y0    <= n_y0;
        r_b3_y1    <= n_y1;
        r_b4_ok    <= (r_b3_job.kind != KIND_REJECT) && (n_lo <= n_hi);
        r_b4_min_x <= r_b3_job.min_x;
        r_b4_max_x <= r_b3_job.max_x;
        r_b4_lo    <= n_lo;
        r_b4_hi    <= n_hi;
        r_b5_ok    <= r_b4_ok;
        r_b5_ddx   <= mag_of(ix - i_ray.p1x);
        r_b5_ddy   <= mag_of(iy - i_ray.p1y);
        r_b6_ok    <= r_b5_ok;
        r_b6_sx    <= PROD_W'(r_b5_ddx) * PROD_W'(r_b5_ddx);
        r_b6_sy    <= PROD_W'(r_b5_ddy) * PROD_W'(r_b5_ddy);
        r_b7_ok    <= r_b6_ok;
        r_b7_sum   <= r_b6_sx + r_b6_sy;
    end

    // distance
    logic [ROOT_W-1:0] root;
    logic [REM_W-1:0]  rem;

    srhd_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_rad  (r_b7_sum),
        .o_root (root),
        .o_rem  (rem)
    );

    logic r_sq_v  [ROOT_W];
    logic r_sq_ok [ROOT_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < ROOT_W; k++) begin
                r_sq_v[k] <= 1'b0;
            end
        end else begin
            r_sq_v[0] <= r_b7_v;
            for (int k = 1; k < ROOT_W; k++) begin
                r_sq_v[k] <= r_sq_v[k-1];
            end
        end
        r_sq_ok[0] <= r_b7_ok;
        for (int k = 1; k < ROOT_W; k++) begin
            r_sq_ok[k] <= r_sq_ok[k-1];
        end
    end

    logic [ROOT_W:0]        rounded;
    logic                   sat;
    logic                   r_strobe;
    logic                   r_hit;
    logic [COORD_WIDTH-1:0] r_dist;

    assign rounded = (ROOT_W + 1)'(root) + (ROOT_W + 1)'(REM_W'(root) < rem);
    assign sat     = rounded[ROOT_W:COORD_WIDTH] != '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_sq_v[ROOT_W-1];
        end
        r_hit  <= r_sq_ok[ROOT_W-1];
        r_dist <= (!r_sq_ok[ROOT_W-1] || sat) ? '1 : rounded[COORD_WIDTH-1:0];
    end

    assign o_strobe       = r_strobe;
    assign o_hit          = r_hit;
    assign o_hit_distance = r_dist;

endmodule

FILE: verif/segment_rect_hit_distance_tb.sv
`timescale 1ns / 1ps

module segment_rect_hit_distance_tb;
    import srhd_pkg::*;

    localparam int  RESULT_LATENCY = 61;
    localparam int  CYCLE_LIMIT    = 300000;
    localparam int  RAND_PER_RAY   = 150;
    localparam longint DIST_SAT    = 64'hFF_FFFF;

    // one rectangle and, where it is obvious, its hit result
    typedef struct {
        logic signed [RECT_WIDTH-1:0] left;
        logic signed [RECT_WIDTH-1:0] top;
        logic [RECT_WIDTH-1:0]        width;
        logic [RECT_WIDTH-1:0]        height;
        bit                           typed;
        bit                           hit;
        logic [COORD_WIDTH-1:0]       dist_q8;
    } t_rect_row;

    typedef struct {
        bit                     hit;
        logic [COORD_WIDTH-1:0] dist_q8;
    } t_hit;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]         i_cfg_idx = CFG_ORIGIN_X;
    logic [CFG_DATA_W-1:0]        i_cfg_data = '0;
    logic                         start = 1'b0;
    logic                         busy;
    logic signed [RECT_WIDTH-1:0] i_rect_left = '0;
    logic signed [RECT_WIDTH-1:0] i_rect_top = '0;
    logic [RECT_WIDTH-1:0]        i_rect_width = '0;
    logic [RECT_WIDTH-1:0]        i_rect_height = '0;
    logic                         o_strobe;
    logic                         o_hit;
    logic [COORD_WIDTH-1:0]       o_hit_distance;

    // local copy of the ray registers
    logic signed [COORD_WIDTH-1:0] ray_org_x;
    logic signed [COORD_WIDTH-1:0] ray_org_y;
    logic signed [DIR_WIDTH-1:0]   ray_dir_x;
    logic signed [DIR_WIDTH-1:0]   ray_dir_y;
    logic [LEN_WIDTH-1:0]          ray_len;

    t_hit   pending_hits[$];
    int     mismatch_cnt = 0;
    int     hit_cnt = 0;
    int     sent_cnt = 0;
    int     ray_cnt = 0;
    int     idle_pct = 0;
    longint cycle_cnt = 0;

    segment_rect_hit_distance dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .start         (start),
        .busy          (busy),
        .i_rect_left   (i_rect_left),
        .i_rect_top    (i_rect_top),
        .i_rect_width  (i_rect_width),
        .i_rect_height (i_rect_height),
        .o_strobe      (o_strobe),
        .o_hit         (o_hit),
        .o_hit_distance(o_hit_distance)
    );

    always #5 i_clk = ~i_clk;

    // run watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, pending_hits.size());
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic report(input string what, input longint got, input longint want);
        $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_cnt++;
    endtask

    // n / d to nearest, ties away from zero
    function automatic longint div_round(input longint n, input longint d);
        longint unsigned an;
        longint unsigned ad;
        longint unsigned q;
        an = (n < 0) ? -n : n;
        ad = (d < 0) ? -d : d;
        q  = (2 * an + ad) / (2 * ad);
        return ((n < 0) != (d < 0)) ? -longint'(q) : longint'(q);
    endfunction

    // integer square root to nearest
    function automatic longint unsigned root_round(input longint unsigned s);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > s)
            b >>= 2;
        while (b != 0) begin
            if (s >= r + b) begin
                s -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        if (s > r)
            r++;
        return r;
    endfunction

    // segment end point on one axis, full width
    function automatic longint seg_end(input longint p1, input logic signed [DIR_WIDTH-1:0] dir);
        return p1 + div_round(longint'(dir) * longint'(ray_len), longint'(1) << DIR_FRAC);
    endfunction

    function automatic t_hit ray_rect_hit(input t_rect_row rc);
        t_hit   res;
        longint rl, rt, rr, rb, p1x, p1y, p2x, p2y;
        longint minx, maxx, miny, maxy, dx, dy, ix, iy, tmp;
        longint unsigned ddx, ddy, dist_q8;
        res.hit     = 1'b0;
        res.dist_q8 = '1;
        rl  = longint'(rc.left) * ONE_PIX;
        rt  = longint'(rc.top) * ONE_PIX;
        rr  = rl + longint'(rc.width) * ONE_PIX;
        rb  = rt + longint'(rc.height) * ONE_PIX;
        p1x = longint'(ray_org_x);
        p1y = longint'(ray_org_y);
        p2x = seg_end(p1x, ray_dir_x);
        p2y = seg_end(p1y, ray_dir_y);
        // half-open bounding box rejection
        if (!(((p1x < p2x ? p1x : p2x) > rl ? (p1x < p2x ? p1x : p2x) : rl) <
              (((p1x > p2x ? p1x : p2x) + ONE_PIX) < rr ?
               ((p1x > p2x ? p1x : p2x) + ONE_PIX) : rr)))
            return res;
        if (!(((p1y < p2y ? p1y : p2y) > rt ? (p1y < p2y ? p1y : p2y) : rt) <
              (((p1y > p2y ? p1y : p2y) + ONE_PIX) < rb ?
               ((p1y > p2y ? p1y : p2y) + ONE_PIX) : rb)))
            return res;
        // clip x against the closed rectangle
        minx = (p1x < p2x) ? p1x : p2x;
        if (rl > minx)
            minx = rl;
        maxx = (p1x > p2x) ? p1x : p2x;
        if (rr < maxx)
            maxx = rr;
        if (minx > maxx)
            return res;
        miny = p1y;
        maxy = p2y;
        dx = p2x - p1x;
        // sloped line unless almost vertical
        if (((dx < 0) ? -dx : dx) * NEAR_VERT_SCALE > ONE_PIX) begin
            dy   = p2y - p1y;
            miny = p1y + div_round((minx - p1x) * dy, dx);
            maxy = p1y + div_round((maxx - p1x) * dy, dx);
        end
        if (miny > maxy) begin
            tmp  = miny;
            miny = maxy;
            maxy = tmp;
        end
        if (maxy > rb)
            maxy = rb;
        if (miny < rt)
            miny = rt;
        if (miny > maxy)
            return res;
        // entry point: near bound taken when origin is at or below it
        ix      = (p1x <= minx) ? minx : maxx;
        iy      = (p1y <= miny) ? miny : maxy;
        ddx     = (ix < p1x) ? p1x - ix : ix - p1x;
        ddy     = (iy < p1y) ? p1y - iy : iy - p1y;
        dist_q8 = root_round(ddx * ddx + ddy * ddy);
        if (dist_q8 > DIST_SAT)
            dist_q8 = DIST_SAT;
        res.hit     = 1'b1;
        res.dist_q8 = dist_q8[COORD_WIDTH-1:0];
        return res;
    endfunction

    // result checker: the receiver cannot stall, every strobe is a transaction
    always @(posedge i_clk) begin
        t_hit want;
        if (i_rst_n && o_strobe) begin
            if (pending_hits.size() == 0) begin
                report("result with nothing outstanding", o_hit, -1);
            end else begin
                want = pending_hits.pop_front();
                if (o_hit !== want.hit)
                    report("hit flag", o_hit, want.hit);
                if (o_hit_distance !== want.dist_q8)
                    report("hit distance", o_hit_distance, want.dist_q8);
                if (want.hit)
                    hit_cnt++;
            end
        end
    end

    // block must be empty before any register write
    task automatic wait_drained();
        while (pending_hits.size() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_ORIGIN_X:   ray_org_x = val;
            CFG_ORIGIN_Y:   ray_org_y = val;
            CFG_DIR_X:      ray_dir_x = val[DIR_WIDTH-1:0];
            CFG_DIR_Y:      ray_dir_y = val[DIR_WIDTH-1:0];
            CFG_RAY_LENGTH: ray_len   = val[LEN_WIDTH-1:0];
            default: ;
        endcase
    endtask

    task automatic set_ray(input logic [23:0] ox, input logic [23:0] oy,
                           input logic [15:0] ddx, input logic [15:0] ddy,
                           input logic [22:0] len);
        wait_drained();
        write_reg(CFG_ORIGIN_X, ox);
        write_reg(CFG_ORIGIN_Y, oy);
        write_reg(CFG_DIR_X, {8'h00, ddx});
        write_reg(CFG_DIR_Y, {8'h00, ddy});
        write_reg(CFG_RAY_LENGTH, {1'b0, len});
        ray_cnt++;
    endtask

    // one rectangle transaction, with optional sender gap afterwards
    task automatic send_rect(input t_rect_row rc);
        t_hit want;
        start         <= 1'b1;
        i_rect_left   <= rc.left;
        i_rect_top    <= rc.top;
        i_rect_width  <= rc.width;
        i_rect_height <= rc.height;
        do
            @(posedge i_clk);
        while (busy);
        if (rc.typed) begin
            want.hit     = rc.hit;
            want.dist_q8 = rc.dist_q8;
        end else begin
            want = ray_rect_hit(rc);
        end
        pending_hits.push_back(want);
        sent_cnt++;
        // each idle cycle drawn on its own so the idle share matches idle_pct
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            do
                @(posedge i_clk);
            while ($urandom_range(99) < idle_pct);
        end
    endtask

    task automatic stop_sending();
        start <= 1'b0;
        @(posedge i_clk);
    endtask

    // mostly rectangles placed around a point of the segment, some anywhere
    function automatic t_rect_row pick_rect();
        t_rect_row rc;
        longint p1x, p1y, px, py;
        int     frac;
        rc.typed   = 1'b0;
        rc.hit     = 1'b0;
        rc.dist_q8 = '0;
        if ($urandom_range(99) < 20) begin
            rc.left   = RECT_WIDTH'($urandom);
            rc.top    = RECT_WIDTH'($urandom);
            rc.width  = RECT_WIDTH'($urandom);
            rc.height = RECT_WIDTH'($urandom);
        end else begin
            p1x  = longint'(ray_org_x);
            p1y  = longint'(ray_org_y);
            frac = $urandom_range(0, 1024);
            px = (p1x + (seg_end(p1x, ray_dir_x) - p1x) * frac / 1024) >>> FRAC_BITS;
            py = (p1y + (seg_end(p1y, ray_dir_y) - p1y) * frac / 1024) >>> FRAC_BITS;
            rc.left   = RECT_WIDTH'(px - longint'($urandom_range(0, 40)));
            rc.top    = RECT_WIDTH'(py - longint'($urandom_range(0, 40)));
            rc.width  = ($urandom_range(99) < 5) ? RECT_WIDTH'($urandom)
                                                 : RECT_WIDTH'($urandom_range(0, 80));
            rc.height = ($urandom_range(99) < 5) ? RECT_WIDTH'($urandom)
                                                 : RECT_WIDTH'($urandom_range(0, 80));
        end
        return rc;
    endfunction

    // after reset the ray is a single pixel at the origin
    t_rect_row reset_rows[] = '{
        '{16'sd0,      16'sd0,      16'd1,     16'd1,     1'b1, 1'b1, 24'd0},
        '{-16'sd32768, -16'sd32768, 16'hFFFF,  16'hFFFF,  1'b1, 1'b1, 24'd0},
        '{16'sd32767,  16'sd0,      16'hFFFF,  16'd1,     1'b1, 1'b0, 24'hFFFFFF},
        '{16'sd0,      16'sd32767,  16'd1,     16'hFFFF,  1'b1, 1'b0, 24'hFFFFFF},
        '{16'sd0,      16'sd0,      16'd0,     16'd5,     1'b1, 1'b0, 24'hFFFFFF},
        '{16'sd0,      16'sd0,      16'd5,     16'd0,     1'b1, 1'b0, 24'hFFFFFF},
        '{-16'sd1,     16'sd0,      16'd1,     16'd1,     1'b1, 1'b0, 24'hFFFFFF},
        '{16'sd0,      -16'sd1,     16'd1,     16'd1,     1'b1, 1'b0, 24'hFFFFFF},
        '{-16'sd1,     -16'sd1,     16'd2,     16'd2,     1'b1, 1'b1, 24'd0},
        '{16'sd1,      16'sd0,      16'd3,     16'd3,     1'b1, 1'b0, 24'hFFFFFF}
    };

    // diagonal ray from (100,-50) of 300 px: rows checked by the predictor
    t_rect_row diag_rows[] = '{
        '{16'sd150,    -16'sd10,    16'd20,    16'd20,    1'b0, 1'b0, 24'd0},
        '{16'sd90,     -16'sd60,    16'd20,    16'd20,    1'b0, 1'b0, 24'd0},
        '{16'sd250,    16'sd100,    16'd400,   16'd400,   1'b0, 1'b0, 24'd0},
        '{16'sd200,    -16'sd300,   16'd10,    16'd100,   1'b0, 1'b0, 24'd0},
        '{16'sd0,      16'sd0,      16'd500,   16'd1,     1'b0, 1'b0, 24'd0},
        '{16'sd311,    16'sd161,    16'd1,     16'd1,     1'b0, 1'b0, 24'd0},
        '{-16'sd32768, -16'sd32768, 16'hFFFF,  16'hFFFF,  1'b0, 1'b0, 24'd0}
    };

    initial begin
        ray_org_x = '0;
        ray_org_y = '0;
        ray_dir_x = DIR_X_RESET;
        ray_dir_y = '0;
        ray_len   = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: default ray, then a sloped one
        foreach (reset_rows[k])
            send_rect(reset_rows[k]);
        stop_sending();
        set_ray(24'sd25600, -24'sd12800, 16'sd11585, 16'sd11585, 23'd76800);
        foreach (diag_rows[k])
            send_rect(diag_rows[k]);
        stop_sending();

        // random rectangles against a range of rays, extremes first
        for (int ph = 0; ph < 10; ph++) begin
            case (ph)
                0: set_ray(24'h800000, 24'h7FFFFF, 16'h8000, 16'h7FFF, 23'h7FFFFF);
                1: set_ray(24'h7FFFFF, 24'h800000, 16'h7FFF, 16'h8000, 23'h7FFFFF);
                2: set_ray(24'sd12345, -24'sd6789, 16'sd0, 16'sd16384, 23'd5000);
                // barely off vertical, still on the steep path
                3: set_ray(24'sd0, 24'sd0, 16'sd1, -16'sd16384, 23'd40000);
                4: set_ray(-24'sd3000, 24'sd700, -16'sd16384, 16'sd0, 23'd20000);
                default: set_ray(24'($urandom_range(0, 1) ? $urandom
                                                          : $urandom_range(0, 131071)),
                                 24'($urandom_range(0, 1) ? $urandom
                                                          : $urandom_range(0, 131071)),
                                 16'($urandom), 16'($urandom),
                                 23'($urandom_range(0, 3) == 0 ? $urandom
                                                               : $urandom_range(0, 65535)));
            endcase
            for (int n = 0; n < RAND_PER_RAY; n++) begin
                idle_pct = (sent_cnt < 500) ? 19 : (sent_cnt < 1000) ? 67 : 0;
                send_rect(pick_rect());
            end
            stop_sending();
        end

        wait_drained();
        repeat (RESULT_LATENCY + 10) @(posedge i_clk);
        $display("%0d rectangles tested against %0d ray settings, %0d hits seen",
                 sent_cnt, ray_cnt, hit_cnt);
        $display("covered extremes of all fields, steep and sloped rays, misses and saturation");
        if (mismatch_cnt == 0 && pending_hits.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
